// File: design/luhn_card_number_check_defines.svh
// assertion macros for the card number check block
// no dependencies; included by files that carry concurrent assertions
`ifndef LUHN_CARD_NUMBER_CHECK_DEFINES_SVH
`define LUHN_CARD_NUMBER_CHECK_DEFINES_SVH
`ifndef ASSERT_OFF
`define LUHN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LUHN_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LUHN_ASSERT(lbl, clk, rst, prop, msg)
`define LUHN_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: design/luhn_pkg.sv
// constants, types and the doubled-digit table for the card number check
// no dependencies
package luhn_pkg;

   localparam int CARD_W     = 63;
   localparam int BCD_DIGITS = 19;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int CNT_W      = 6;
   localparam int COUNT_W    = 5;
   localparam int CLASS_W    = 2;

   localparam logic [CNT_W-1:0] LAST_BIT   = CNT_W'(CARD_W - 1);
   localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(BCD_DIGITS - 1);

   localparam logic [COUNT_W-1:0] LEN_SHORT = 5'd13;
   localparam logic [COUNT_W-1:0] LEN_MID   = 5'd15;
   localparam logic [COUNT_W-1:0] LEN_LONG  = 5'd16;

   localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_LEAD4   = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_LEAD3X  = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_LEAD5X  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_DIGIT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // doubled digit with a two-digit product folded to its digit sum
   function automatic logic [3:0] fold_double(input logic [3:0] d);
      logic [3:0] r;
      case (d)
         4'd0: r = 4'd0;
         4'd1: r = 4'd2;
         4'd2: r = 4'd4;
         4'd3: r = 4'd6;
         4'd4: r = 4'd8;
         4'd5: r = 4'd1;
         4'd6: r = 4'd3;
         4'd7: r = 4'd5;
         4'd8: r = 4'd7;
         4'd9: r = 4'd9;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

// File: design/luhn_card_number_check.sv
// card number check: binary to decimal, Luhn mod-10 sum, issuer class
// depends on luhn_pkg and luhn_card_number_check_defines.svh
//
//   channel  ports                                          dir
//   req      req_valid, req_stall, req_card_number          in
//   rsp      rsp_valid, rsp_stall, rsp_issuer_class,        out
//            rsp_luhn_ok, rsp_digit_count
//
// one item is shifted through the decimal converter with add-3 correction, one
// input bit per step, then its digits are walked from the right through one adder,
// then the result register is loaded.
// a new item is taken in the cycle after the result is loaded, even if it waits.
// a stalled result holds the sequencer in its last step. reset is synchronous.
`include "luhn_card_number_check_defines.svh"

module luhn_card_number_check
   import luhn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CARD_W-1:0]   req_card_number,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CLASS_W-1:0]  rsp_issuer_class,
   output logic                rsp_luhn_ok,
   output logic [COUNT_W-1:0]  rsp_digit_count
);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CARD_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [3:0]           sum_ff, sum_in;
   logic [3:0]           prev_ff, prev_in;
   logic [3:0]           lead_ff, lead_in;
   logic [3:0]           second_ff, second_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0]   cls_ff, cls_in;
   logic                 ok_ff, ok_in;
   logic [COUNT_W-1:0]   len_ff, len_in;

   logic [BCD_W-1:0]     bcd_adj;
   logic [3:0]           digit;
   logic [3:0]           addend;
   logic [4:0]           total;
   logic                 req_xfer;
   logic                 rsp_free;
   logic                 luhn_ok;
   logic [CLASS_W-1:0]   cls;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // add 3 to every decimal digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // shared digit adder, doubling on odd positions from the right
   assign digit  = bcd_ff[3:0];
   assign addend = cnt_ff[0] ? fold_double(digit) : digit;
   assign total  = {1'b0, sum_ff} + {1'b0, addend};

   assign luhn_ok = (sum_ff == 4'd0);

   always_comb begin
      cls = CLS_INVALID;
      if (count_ff == LEN_SHORT) begin
         if (lead_ff == 4'd4) begin
            cls = CLS_LEAD4;
         end
      end else if (count_ff == LEN_MID) begin
         if (lead_ff == 4'd3 && (second_ff == 4'd4 || second_ff == 4'd7)) begin
            cls = CLS_LEAD3X;
         end
      end else if (count_ff == LEN_LONG) begin
         if (lead_ff == 4'd4) begin
            cls = CLS_LEAD4;
         end else if (lead_ff == 4'd5 && second_ff >= 4'd1 && second_ff <= 4'd5) begin
            cls = CLS_LEAD5X;
         end
      end
      if (!luhn_ok) begin
         cls = CLS_INVALID;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      lead_in      = lead_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cls_in       = cls_ff;
      ok_in        = ok_ff;
      len_in       = len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               bin_in    = req_card_number;
               bcd_in    = '0;
               cnt_in    = '0;
               sum_in    = '0;
               prev_in   = '0;
               lead_in   = '0;
               second_in = '0;
               count_in  = '0;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[CARD_W-1]};
            bin_in = {bin_ff[CARD_W-2:0], 1'b0};
            if (cnt_ff == LAST_BIT) begin
               cnt_in   = '0;
               state_in = ST_DIGIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIGIT: begin
            bcd_in  = {4'd0, bcd_ff[BCD_W-1:4]};
            sum_in  = (total >= 5'd10) ? 4'(total - 5'd10) : total[3:0];
            prev_in = digit;
            // highest nonzero digit seen so far sets length and leading pair
            if (digit != 4'd0) begin
               count_in  = cnt_ff[COUNT_W-1:0] + 1'b1;
               lead_in   = digit;
               second_in = prev_ff;
            end
            if (cnt_ff == LAST_DIGIT) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               cls_in       = cls;
               ok_in        = luhn_ok;
               len_in       = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      sum_ff    <= sum_in;
      prev_ff   <= prev_in;
      lead_ff   <= lead_in;
      second_ff <= second_in;
      count_ff  <= count_in;
      cls_ff    <= cls_in;
      ok_ff     <= ok_in;
      len_ff    <= len_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_issuer_class = cls_ff;
   assign rsp_luhn_ok      = ok_ff;
   assign rsp_digit_count  = len_ff;

   `LUHN_ASSERT(a_start_conv, clock, reset, req_xfer |=> (state_ff == ST_CONV), "transfer did not start conversion")
   `LUHN_ASSERT_NEVER(a_digit_cnt, clock, reset, (state_ff == ST_DIGIT) && (cnt_ff > LAST_DIGIT), "digit index past last digit")
   `LUHN_ASSERT(a_fail_invalid, clock, reset, (rsp_valid && !rsp_luhn_ok) |-> (rsp_issuer_class == CLS_INVALID), "class set on failed checksum")
   `LUHN_ASSERT(a_class_len, clock, reset, (rsp_valid && rsp_issuer_class != CLS_INVALID) |-> (rsp_digit_count == LEN_SHORT || rsp_digit_count == LEN_MID || rsp_digit_count == LEN_LONG), "class set on bad length")
   `LUHN_ASSERT(a_sum_range, clock, reset, (state_ff == ST_DIGIT || state_ff == ST_DONE) |-> (sum_ff < 4'd10), "running sum out of range")

endmodule
